@@ src/ymr_pkg.sv @@
// ----------------------------------------------------------------------------
// ymr_pkg
// Shared constants and types of the YMODEM receiver.
// ----------------------------------------------------------------------------
package ymr_pkg;

	localparam logic [7:0] SOH_B = 8'h01;
	localparam logic [7:0] STX_B = 8'h02;
	localparam logic [7:0] EOT_B = 8'h04;
	localparam logic [7:0] ACK_B = 8'h06;
	localparam logic [7:0] NAK_B = 8'h15;
	localparam logic [7:0] CAN_B = 8'h18;
	localparam logic [7:0] C_B   = 8'h43;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [30:0] SIZE_MAX31 = 31'h7FFF_FFFF;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_BYTE  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;
	localparam logic [1:0] KIND_BAD   = 2'd3;

	localparam logic [1:0] OK_TX     = 2'd0;
	localparam logic [1:0] OK_DATA   = 2'd1;
	localparam logic [1:0] OK_COMMIT = 2'd2;
	localparam logic [1:0] OK_FINISH = 2'd3;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_CANCEL = 2'd1;
	localparam logic [1:0] ST_BIG    = 2'd2;

	localparam logic [2:0] REG_BASE  = 3'd0;
	localparam logic [2:0] REG_MAX   = 3'd1;
	localparam logic [2:0] REG_CHAR  = 3'd2;
	localparam logic [2:0] REG_INIT  = 3'd3;
	localparam logic [2:0] REG_START = 3'd4;
	localparam logic [2:0] REG_CANTO = 3'd5;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [7:0]  tx_byte;
		logic [7:0]  payload_byte;
		logic [9:0]  payload_offset;
		logic [31:0] write_address;
		logic [10:0] block_length;
		logic [31:0] running_total;
		logic [30:0] parsed_size;
		logic        size_known;
		logic [1:0]  status;
		logic        last;
	} res_t;

	// classified item from the front end
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] rx_byte;
	} item_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

@@ src/ymr_front.sv @@
// ----------------------------------------------------------------------------
// ymr_front
// Accepts input words, drops unknown kinds and queues the rest.
// ----------------------------------------------------------------------------
module ymr_front import ymr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       in_item,
	output logic        q_valid,
	input  logic        q_pop,
	output item_t       q_item
);

	item_t           mem_q [QDEPTH];
	logic [QAW-1:0]  wr_q, rd_q;
	logic [QAW:0]    cnt_q;
	logic            push;

	assign in_ready = (cnt_q != (QAW+1)'(QDEPTH));
	// kind 3 is dropped here
	assign push = in_valid && in_ready && (in_item.kind != KIND_BAD);
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop && q_valid) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(q_pop && q_valid);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAW+1)'(QDEPTH)) else $error("queue overflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !(q_pop && q_valid)) else $error("pop empty");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!push && !(q_pop && q_valid)) |=> $stable(cnt_q)) else $error("count moved");
`endif

endmodule

@@ src/ymr_back.sv @@
// ----------------------------------------------------------------------------
// ymr_back
// Protocol engine: runs one item per cycle, when the 4-slot result buffer is
// empty or its last result leaves; drains one result per cycle on res_ready.
// ----------------------------------------------------------------------------
module ymr_back import ymr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  item_t       q_item,
	input  logic [31:0] base_address,
	input  logic [31:0] size_cap,
	input  logic [15:0] char_to,
	input  logic [15:0] init_to,
	input  logic [15:0] start_to,
	input  logic [15:0] can_to,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

	localparam logic [3:0] P_IDLE = 4'd0, P_HWAIT = 4'd1, P_HCAN = 4'd2, P_DWAIT = 4'd3,
		P_DCAN = 4'd4, P_NUM = 4'd5, P_INV = 4'd6, P_BODY = 4'd7, P_CHI = 4'd8, P_CLO = 4'd9;

	logic [3:0]  phase_q;
	logic [15:0] tick_q;
	logic        long_q, hdr_q, sval_q, cval_q;
	logic [7:0]  bnum_q, exp_q, rcrc_hi_q;
	logic [10:0] idx_q;
	logic [15:0] crc_q;
	logic [31:0] total_q;
	logic [30:0] size_q, cand_q;
	logic [1:0]  hf_q;

	// result buffer
	res_t        buf_q [4];
	logic [2:0]  bcnt_q;
	logic [1:0]  bidx_q;

	logic [3:0]  phase_d;
	logic [15:0] tick_d;
	logic        long_d, hdr_d, sval_d, cval_d;
	logic [7:0]  bnum_d, exp_d, rcrc_hi_d;
	logic [10:0] idx_d;
	logic [15:0] crc_d;
	logic [31:0] total_d;
	logic [30:0] size_d, cand_d;
	logic [1:0]  hf_d;
	res_t        r_d [4];
	logic [2:0]  n_d;

	logic [7:0]  b;
	logic [15:0] tick_inc, lim;
	logic [10:0] len;
	logic [32:0] sum_len;
	logic        digit, crc_ok, tmo;
	logic [34:0] mul10;

	// take the next word when the buffer is empty or while the last buffered result leaves
	assign q_pop = q_valid && ((bcnt_q == '0) || (bcnt_q == 3'd1 && res_ready));
	assign res_valid = (bcnt_q != '0);
	assign res = buf_q[bidx_q];

	always_comb begin
		b = q_item.rx_byte;
		len = long_q ? 11'd1024 : 11'd128;
		sum_len = {1'b0, total_q} + 33'(len);
		tick_inc = tick_q + 16'd1;
		digit = (b >= 8'h30) && (b <= 8'h39);
		mul10 = {4'd0, cand_q} * 35'd10 + 35'(b - 8'h30);
		crc_ok = ({rcrc_hi_q, b} == crc_q);
		case (phase_q)
			P_HWAIT: lim = init_to;
			P_HCAN, P_DCAN: lim = can_to;
			P_DWAIT: lim = start_to;
			default: lim = char_to;
		endcase
		tmo = (tick_inc >= lim);

		phase_d = phase_q; tick_d = tick_q; long_d = long_q; hdr_d = hdr_q;
		sval_d = sval_q; cval_d = cval_q; bnum_d = bnum_q; exp_d = exp_q;
		rcrc_hi_d = rcrc_hi_q; idx_d = idx_q; crc_d = crc_q; total_d = total_q;
		size_d = size_q; cand_d = cand_q; hf_d = hf_q;
		n_d = '0;
		for (int i = 0; i < 4; i++) r_d[i] = '0;

		if (q_pop) begin
			case (q_item.kind)
				KIND_START: begin
					total_d = '0; size_d = '0; sval_d = 1'b0; exp_d = '0; hdr_d = 1'b1;
					r_d[0].tx_byte = C_B; n_d = 3'd1;
					phase_d = P_HWAIT; tick_d = '0;
				end
				KIND_TICK: begin
					if (phase_q != P_IDLE) begin
						tick_d = tick_inc;
						if (tmo) begin
							tick_d = '0;
							if (phase_q == P_HWAIT || phase_q == P_HCAN) begin
								r_d[0].tx_byte = C_B; n_d = 3'd1; phase_d = P_HWAIT;
							end else if (phase_q == P_DWAIT || phase_q == P_DCAN) begin
								r_d[0].tx_byte = NAK_B; n_d = 3'd1; phase_d = P_DWAIT;
							end else begin
								r_d[0].tx_byte = NAK_B; n_d = 3'd1;
								if (hdr_q) begin r_d[1].tx_byte = C_B; n_d = 3'd2; end
								phase_d = hdr_q ? P_HWAIT : P_DWAIT;
							end
						end
					end
				end
				KIND_BYTE: begin
					tick_d = '0;
					case (phase_q)
						P_HWAIT, P_DWAIT: begin
							if (phase_q == P_DWAIT && b == EOT_B) begin
								r_d[0].tx_byte = ACK_B;
								r_d[1].tx_byte = CAN_B;
								r_d[2].tx_byte = CAN_B;
								if (sval_q && total_q > {1'b0, size_q}) total_d = {1'b0, size_q};
								r_d[3].out_kind = OK_FINISH;
								r_d[3].running_total = total_d;
								r_d[3].status = ST_DONE;
								r_d[3].parsed_size = size_q;
								r_d[3].size_known = sval_q;
								n_d = 3'd4; phase_d = P_IDLE;
							end else if (b == SOH_B || b == STX_B) begin
								long_d = (b == STX_B); phase_d = P_NUM; crc_d = '0;
								idx_d = '0; hf_d = '0; cand_d = '0; cval_d = 1'b0;
							end else if (b == CAN_B) begin
								phase_d = (phase_q == P_HWAIT) ? P_HCAN : P_DCAN;
							end else begin
								r_d[0].tx_byte = (phase_q == P_HWAIT) ? C_B : NAK_B;
								n_d = 3'd1;
							end
						end
						P_HCAN, P_DCAN: begin
							if (b == CAN_B) begin
								r_d[0].out_kind = OK_FINISH;
								r_d[0].running_total = total_q;
								r_d[0].status = ST_CANCEL;
								r_d[0].parsed_size = size_q;
								r_d[0].size_known = sval_q;
								n_d = 3'd1; phase_d = P_IDLE;
							end else begin
								r_d[0].tx_byte = (phase_q == P_HCAN) ? C_B : NAK_B;
								n_d = 3'd1;
								phase_d = (phase_q == P_HCAN) ? P_HWAIT : P_DWAIT;
							end
						end
						P_NUM: begin bnum_d = b; phase_d = P_INV; end
						P_INV: begin
							if (bnum_q + b != 8'hFF) begin
								r_d[0].tx_byte = NAK_B; n_d = 3'd1;
								if (hdr_q) begin r_d[1].tx_byte = C_B; n_d = 3'd2; end
								phase_d = hdr_q ? P_HWAIT : P_DWAIT;
							end else phase_d = P_BODY;
						end
						P_BODY: begin
							crc_d = crc_step(crc_q, b);
							if (hdr_q) begin
								case (hf_q)
									2'd0: if (b == 8'h00) hf_d = 2'd1;
									2'd1: begin
										if (b == 8'h20) begin
											cand_d = '0; cval_d = 1'b1; hf_d = 2'd2;
										end else if (digit) begin
											cand_d = 31'(b - 8'h30); cval_d = 1'b1; hf_d = 2'd2;
										end else hf_d = 2'd3;
									end
									2'd2: begin
										if (digit) cand_d = (mul10 > 35'(SIZE_MAX31)) ?
											SIZE_MAX31 : mul10[30:0];
										else hf_d = 2'd3;
									end
									default: ;
								endcase
							end else begin
								r_d[0].out_kind = OK_DATA;
								r_d[0].payload_byte = b;
								r_d[0].payload_offset = idx_q[9:0];
								n_d = 3'd1;
							end
							idx_d = idx_q + 11'd1;
							if (idx_d >= len) phase_d = P_CHI;
						end
						P_CHI: begin rcrc_hi_d = b; phase_d = P_CLO; end
						P_CLO: begin
							phase_d = hdr_q ? P_HWAIT : P_DWAIT;
							if (hdr_q) begin
								if (crc_ok && bnum_q == 8'd0) begin
									r_d[0].tx_byte = ACK_B;
									sval_d = cval_q;
									size_d = cval_q ? cand_q : '0;
									hdr_d = 1'b0; exp_d = 8'd1;
									r_d[1].tx_byte = C_B; n_d = 3'd2;
									phase_d = P_DWAIT;
								end else begin
									r_d[0].tx_byte = NAK_B; r_d[1].tx_byte = C_B; n_d = 3'd2;
								end
							end else if (!crc_ok) begin
								r_d[0].tx_byte = NAK_B; n_d = 3'd1;
							end else if (bnum_q == exp_q) begin
								if (sum_len > {1'b0, size_cap}) begin
									r_d[0].out_kind = OK_FINISH;
									r_d[0].running_total = total_q;
									r_d[0].status = ST_BIG;
									r_d[0].parsed_size = size_q;
									r_d[0].size_known = sval_q;
									n_d = 3'd1; phase_d = P_IDLE;
								end else begin
									r_d[0].out_kind = OK_COMMIT;
									r_d[0].write_address = base_address + total_q;
									r_d[0].block_length = len;
									r_d[0].running_total = sum_len[31:0];
									r_d[0].parsed_size = size_q;
									r_d[0].size_known = sval_q;
									total_d = sum_len[31:0];
									r_d[1].tx_byte = ACK_B; n_d = 3'd2;
									exp_d = exp_q + 8'd1;
								end
							end else begin
								r_d[0].tx_byte = (bnum_q == exp_q - 8'd1) ? ACK_B : NAK_B;
								n_d = 3'd1;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
			// flag the final result of this word
			case (n_d)
				3'd1: r_d[0].last = 1'b1;
				3'd2: r_d[1].last = 1'b1;
				3'd3: r_d[2].last = 1'b1;
				3'd4: r_d[3].last = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < 4; i++) buf_q[i] <= r_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE; tick_q <= '0; hdr_q <= 1'b0; sval_q <= 1'b0;
			exp_q <= '0; total_q <= '0; size_q <= '0;
			long_q <= 1'b0; bnum_q <= '0; rcrc_hi_q <= '0; crc_q <= '0;
			cand_q <= '0; cval_q <= 1'b0; hf_q <= '0; idx_q <= '0;
			bcnt_q <= '0; bidx_q <= '0;
		end else begin
			if (q_pop) begin
				phase_q <= phase_d; tick_q <= tick_d; hdr_q <= hdr_d; sval_q <= sval_d;
				exp_q <= exp_d; total_q <= total_d; size_q <= size_d;
				long_q <= long_d; bnum_q <= bnum_d; rcrc_hi_q <= rcrc_hi_d; crc_q <= crc_d;
				cand_q <= cand_d; cval_q <= cval_d; hf_q <= hf_d; idx_q <= idx_d;
				bcnt_q <= n_d; bidx_q <= '0;
			end else if (res_valid && res_ready) begin
				bcnt_q <= bcnt_q - 3'd1;
				bidx_q <= bidx_q + 2'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q <= 3'd4) else $error("result buffer overrun");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !(bcnt_q == 3'd1 && res_ready)) |-> !q_pop)
		else $error("item taken while draining");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && bcnt_q == 3'd1) |-> res.last) else $error("last missing");
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == P_IDLE) |-> ##0 1'b1 ##1 (phase_q <= P_CLO)) else $error("bad phase");
`endif

endmodule

@@ src/ymr_regs.sv @@
// ----------------------------------------------------------------------------
// ymr_regs
// APB register file for base address, size limit and timeouts.
// ----------------------------------------------------------------------------
module ymr_regs import ymr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [31:0] base_address,
	output logic [31:0] size_cap,
	output logic [15:0] char_to,
	output logic [15:0] init_to,
	output logic [15:0] start_to,
	output logic [15:0] can_to
);

	logic [2:0] ridx;
	logic       wr;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address <= '0; size_cap <= '0;
			char_to <= 16'd1000; init_to <= 16'd3000;
			start_to <= 16'd10000; can_to <= 16'd100;
		end else if (wr) begin
			case (ridx)
				REG_BASE:  base_address <= pwdata;
				REG_MAX:   size_cap <= pwdata;
				REG_CHAR:  char_to <= pwdata[15:0];
				REG_INIT:  init_to <= pwdata[15:0];
				REG_START: start_to <= pwdata[15:0];
				REG_CANTO: can_to <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_BASE:  prdata = base_address;
			REG_MAX:   prdata = size_cap;
			REG_CHAR:  prdata = {16'd0, char_to};
			REG_INIT:  prdata = {16'd0, init_to};
			REG_START: prdata = {16'd0, start_to};
			REG_CANTO: prdata = {16'd0, can_to};
			default:   prdata = '0;
		endcase
	end

endmodule

@@ src/ymodem_receiver_top.sv @@
// Latency: a word's first result appears the cycle after it leaves the queue;
// results drain one per cycle while m_tready is high, up to four per word.
// Throughput: one word per cycle when it causes at most one result and m_tready
// stays high; a word with more results holds the engine until the last leaves.
// Reset: arst_n clears the queue, protocol state and registers to their defaults.
// ----------------------------------------------------------------------------
// ymodem_receiver_top
// YMODEM receiver with CRC-16 checking and block commit stream.
// ----------------------------------------------------------------------------
module ymodem_receiver_top import ymr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // rx_byte[7:0]
	input  logic [1:0]   s_tuser,   // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	// tx_byte[7:0], payload_byte[15:8], payload_offset[25:16], write_address[57:26],
	// block_length[68:58], running_total[100:69], parsed_size[131:101],
	// size_known[132], status[134:133], zero[135]
	output logic [135:0] m_tdata,
	output logic [1:0]   m_tuser,   // out_kind
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	item_t       in_item, q_item;
	logic        q_valid, q_pop;
	logic [31:0] base_address, size_cap;
	logic [15:0] char_to, init_to, start_to, can_to;
	res_t        res;

	assign in_item.kind = s_tuser;
	assign in_item.rx_byte = s_tdata;

	ymr_regs u_regs (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.pready, .base_address, .size_cap, .char_to, .init_to, .start_to, .can_to);

	ymr_front u_front (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.in_item, .q_valid, .q_pop, .q_item);

	ymr_back u_back (.clk, .arst_n, .q_valid, .q_pop, .q_item, .base_address, .size_cap,
		.char_to, .init_to, .start_to, .can_to, .res_valid(m_tvalid), .res_ready(m_tready),
		.res);

	assign m_tuser = res.out_kind;
	assign m_tlast = res.last;
	assign m_tdata = {1'b0, res.status, res.size_known, res.parsed_size, res.running_total,
		res.block_length, res.write_address, res.payload_offset, res.payload_byte,
		res.tx_byte};

endmodule

@@ bench/ymr_checker.sv @@
// ----------------------------------------------------------------------------
// ymr_checker
// Watches the byte, result and register channels of the YMODEM receiver,
// predicts every result word from the accepted input words and compares
// each result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ymr_checker import ymr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,   // rx_byte[7:0]
	input  logic [1:0]   s_tuser,   // kind
	input  logic         m_tvalid,
	input  logic         m_tready,
	// tx_byte[7:0], payload_byte[15:8], payload_offset[25:16], write_address[57:26],
	// block_length[68:58], running_total[100:69], parsed_size[131:101],
	// size_known[132], status[134:133], zero[135]
	input  logic [135:0] m_tdata,
	input  logic [1:0]   m_tuser,   // out_kind
	input  logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           errors,
	output int           pending
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_HWAIT, PH_HCAN, PH_DWAIT, PH_DCAN,
		PH_NUM, PH_INV, PH_BODY, PH_CHI, PH_CLO
	} phase_e;

	logic [31:0] base_addr, size_limit;
	logic [15:0] to_char, to_init, to_start, to_can;

	phase_e      ph;
	logic [15:0] ticks;
	logic        long_blk;
	logic [7:0]  blk_num, want_num;
	logic [10:0] idx;
	logic [15:0] crc_acc, crc_rx;
	logic [31:0] total;
	logic [30:0] fsize, cand;
	logic        fsize_ok, cand_ok, in_hdr;
	logic [1:0]  field;

	res_t expected_words[$];
	res_t item_words[$];

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ d[i];
			c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	task automatic clear_model();
		base_addr = 0; size_limit = 0;
		to_char = 16'd1000; to_init = 16'd3000; to_start = 16'd10000; to_can = 16'd100;
		ph = PH_IDLE; ticks = 0; long_blk = 0; blk_num = 0; want_num = 0; idx = 0;
		crc_acc = 0; crc_rx = 0; total = 0; fsize = 0; fsize_ok = 0;
		cand = 0; cand_ok = 0; in_hdr = 0; field = 0;
	endtask

	task automatic add(input logic [1:0] k, input logic [7:0] tx, input logic [7:0] pb,
			input logic [9:0] off, input logic [31:0] addr, input logic [10:0] blen,
			input logic [31:0] tot, input logic [1:0] st);
		res_t r;
		if (item_words.size() >= 4)
			return;
		r = '0;
		r.out_kind = k; r.tx_byte = tx; r.payload_byte = pb; r.payload_offset = off;
		r.write_address = addr; r.block_length = blen; r.running_total = tot; r.status = st;
		if (k == OK_COMMIT || k == OK_FINISH) begin
			r.parsed_size = fsize;
			r.size_known = fsize_ok;
		end
		item_words.push_back(r);
	endtask

	task automatic xmit(input logic [7:0] b);
		add(OK_TX, b, 0, 0, 0, 0, 0, ST_DONE);
	endtask

	task automatic close_session(input logic [1:0] st);
		add(OK_FINISH, 0, 0, 0, 0, 0, total, st);
		ph = PH_IDLE;
	endtask

	function automatic logic expired(input logic [15:0] lim);
		ticks = ticks + 16'd1;
		return ticks >= lim;
	endfunction

	task automatic rewait();
		ph = in_hdr ? PH_HWAIT : PH_DWAIT;
		ticks = 0;
	endtask

	task automatic reject();
		xmit(NAK_B);
		if (in_hdr)
			xmit(C_B);
		rewait();
	endtask

	task automatic open_block(input logic [7:0] b);
		long_blk = (b == STX_B);
		ph = PH_NUM; ticks = 0; crc_acc = 0; idx = 0;
		field = 0; cand = 0; cand_ok = 0;
	endtask

	task automatic parse_header(input logic [7:0] b);
		logic       dig;
		logic [63:0] v;
		dig = (b >= 8'h30 && b <= 8'h39);
		case (field)
			2'd0: if (b == 8'h00) field = 2'd1;
			2'd1: begin
				if (b == 8'h20) begin
					cand = 0; cand_ok = 1; field = 2'd2;
				end else if (dig) begin
					cand = 31'(b - 8'h30); cand_ok = 1; field = 2'd2;
				end else
					field = 2'd3;
			end
			2'd2: begin
				if (dig) begin
					v = 64'(cand) * 10 + 64'(b - 8'h30);
					cand = (v > 64'(SIZE_MAX31)) ? SIZE_MAX31 : v[30:0];
				end else
					field = 2'd3;
			end
			default: ;
		endcase
	endtask

	task automatic end_block();
		logic [10:0] len;
		logic [32:0] sum;
		len = long_blk ? 11'd1024 : 11'd128;
		sum = {1'b0, total} + 33'(len);
		if (in_hdr) begin
			if (crc_rx == crc_acc && blk_num == 8'd0) begin
				xmit(ACK_B);
				fsize_ok = cand_ok;
				fsize = cand_ok ? cand : 31'd0;
				in_hdr = 0;
				want_num = 8'd1;
				xmit(C_B);
				rewait();
			end else
				reject();
			return;
		end
		if (crc_rx != crc_acc) begin
			reject();
			return;
		end
		if (blk_num == want_num) begin
			if (sum > {1'b0, size_limit}) begin
				close_session(ST_BIG);
				return;
			end
			add(OK_COMMIT, 0, 0, 0, base_addr + total, len, sum[31:0], ST_DONE);
			total = sum[31:0];
			xmit(ACK_B);
			want_num = want_num + 8'd1;
		end else if (blk_num == want_num - 8'd1)
			xmit(ACK_B);
		else
			xmit(NAK_B);
		rewait();
	endtask

	task automatic step(input logic [1:0] k, input logic [7:0] b);
		logic [10:0] len;
		len = long_blk ? 11'd1024 : 11'd128;
		item_words.delete();
		if (k == KIND_START) begin
			total = 0; fsize = 0; fsize_ok = 0; want_num = 0; in_hdr = 1;
			xmit(C_B);
			rewait();
		end else if (k == KIND_TICK) begin
			case (ph)
				PH_HWAIT, PH_HCAN:
					if (expired(ph == PH_HWAIT ? to_init : to_can)) begin
						xmit(C_B); rewait();
					end
				PH_DWAIT, PH_DCAN:
					if (expired(ph == PH_DWAIT ? to_start : to_can)) begin
						xmit(NAK_B); rewait();
					end
				PH_NUM, PH_INV, PH_BODY, PH_CHI, PH_CLO:
					if (expired(to_char)) reject();
				default: ;
			endcase
		end else if (k == KIND_BYTE) begin
			ticks = 0;
			case (ph)
				PH_HWAIT: begin
					if (b == SOH_B || b == STX_B) open_block(b);
					else if (b == CAN_B) ph = PH_HCAN;
					else xmit(C_B);
				end
				PH_HCAN: begin
					if (b == CAN_B) close_session(ST_CANCEL);
					else begin xmit(C_B); rewait(); end
				end
				PH_DWAIT: begin
					if (b == EOT_B) begin
						xmit(ACK_B);
						if (fsize_ok && total > {1'b0, fsize}) total = {1'b0, fsize};
						xmit(CAN_B);
						xmit(CAN_B);
						close_session(ST_DONE);
					end else if (b == CAN_B) ph = PH_DCAN;
					else if (b == SOH_B || b == STX_B) open_block(b);
					else xmit(NAK_B);
				end
				PH_DCAN: begin
					if (b == CAN_B) close_session(ST_CANCEL);
					else begin xmit(NAK_B); rewait(); end
				end
				PH_NUM: begin blk_num = b; ph = PH_INV; end
				PH_INV: begin
					if (blk_num + b != 8'hFF) reject();
					else ph = PH_BODY;
				end
				PH_BODY: begin
					crc_acc = crc_next(crc_acc, b);
					if (in_hdr) parse_header(b);
					else add(OK_DATA, 0, b, idx[9:0], 0, 0, 0, ST_DONE);
					idx = idx + 11'd1;
					if (idx >= len) ph = PH_CHI;
				end
				PH_CHI: begin crc_rx = {b, 8'h00}; ph = PH_CLO; end
				PH_CLO: begin crc_rx[7:0] = b; end_block(); end
				default: ;
			endcase
		end
		if (item_words.size() > 0)
			item_words[item_words.size() - 1].last = 1'b1;
		foreach (item_words[i])
			expected_words.push_back(item_words[i]);
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
	endtask

	task automatic compare_word();
		res_t e;
		if (expected_words.size() == 0) begin
			report("result word with nothing predicted", m_tdata[63:0], 0);
			return;
		end
		e = expected_words.pop_front();
		if (m_tuser !== e.out_kind) report("out_kind", m_tuser, e.out_kind);
		if (m_tdata[7:0] !== e.tx_byte) report("tx_byte", m_tdata[7:0], e.tx_byte);
		if (m_tdata[15:8] !== e.payload_byte)
			report("payload_byte", m_tdata[15:8], e.payload_byte);
		if (m_tdata[25:16] !== e.payload_offset)
			report("payload_offset", m_tdata[25:16], e.payload_offset);
		if (m_tdata[57:26] !== e.write_address)
			report("write_address", m_tdata[57:26], e.write_address);
		if (m_tdata[68:58] !== e.block_length)
			report("block_length", m_tdata[68:58], e.block_length);
		if (m_tdata[100:69] !== e.running_total)
			report("running_total", m_tdata[100:69], e.running_total);
		if (m_tdata[131:101] !== e.parsed_size)
			report("parsed_size", m_tdata[131:101], e.parsed_size);
		if (m_tdata[132] !== e.size_known) report("size_known", m_tdata[132], e.size_known);
		if (m_tdata[134:133] !== e.status) report("status", m_tdata[134:133], e.status);
		if (m_tlast !== e.last) report("tlast", m_tlast, e.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			expected_words.delete();
		end else begin
			// compare before predicting: a word accepted now cannot have results yet
			if (m_tvalid && m_tready)
				compare_word();
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_BASE:  base_addr = pwdata;
					REG_MAX:   size_limit = pwdata;
					REG_CHAR:  to_char = pwdata[15:0];
					REG_INIT:  to_init = pwdata[15:0];
					REG_START: to_start = pwdata[15:0];
					REG_CANTO: to_can = pwdata[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				step(s_tuser, s_tdata);
		end
		pending = expected_words.size();
	end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives a YMODEM session into the receiver: ignored words, header stage
// faults, a header block, data stage faults, one data block and EOT, then a
// random stretch and a double cancel. Results are checked by ymr_checker;
// this module decides the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import ymr_pkg::*;

	localparam int LIMIT = 200000;

	logic         clk, arst_n;
	logic         s_tvalid, s_tready;
	logic [7:0]   s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid, m_tready;
	logic [135:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         psel, penable, pwrite, pready;
	logic [4:0]   paddr;
	logic [31:0]  pwdata, prdata;
	int           errors, pending;
	int           cycles = 0;
	logic [7:0]   blk [1024];

	ymodem_receiver_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	ymr_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: random stall before each word
	initial begin
		m_tready = 0;
		forever begin
			int g;
			g = $urandom_range(0, 14);
			if (g > 0) begin
				m_tready <= 0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic put(input logic [1:0] k, input logic [7:0] b);
		int g;
		g = $urandom_range(0, 14);
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= k;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic ticks(input int n);
		repeat (n) put(KIND_TICK, 8'($urandom));
	endtask

	task automatic idle_out();
		s_tvalid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic wr(input logic [2:0] idx, input logic [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic set_timeouts(input int c, input int i, input int s, input int n);
		wr(REG_CHAR, c); wr(REG_INIT, i); wr(REG_START, s); wr(REG_CANTO, n);
	endtask

	// size_mode: 0 digits right after NUL, 1 space then digits, 2 lone space,
	// 3 no size, 4 saturating size
	task automatic send_block(input bit long_b, input logic [7:0] num, input bit bad_comp,
			input bit bad_crc, input int cut, input bit hdr, input int size_mode);
		int len, p;
		string s;
		logic [15:0] crc;
		logic fb;
		len = long_b ? 1024 : 128;
		if (hdr) begin
			for (int i = 0; i < len; i++) blk[i] = 8'h00;
			p = $urandom_range(1, 8);
			for (int i = 0; i < p; i++) blk[i] = 8'h61 + 8'($urandom_range(0, 25));
			p++;
			case (size_mode)
				0: s = $sformatf("%0d 644", $urandom_range(0, 400));
				1: s = $sformatf(" %0d", $urandom_range(0, 5000));
				2: s = " ";
				3: s = "x12";
				default: s = "99999999999 1";
			endcase
			for (int i = 0; i < s.len(); i++) blk[p + i] = s[i];
		end else begin
			for (int i = 0; i < len; i++)
				blk[i] = ($urandom_range(0, 7) == 0) ? {8{1'($urandom)}} : 8'($urandom);
		end
		put(KIND_BYTE, long_b ? STX_B : SOH_B);
		put(KIND_BYTE, num);
		put(KIND_BYTE, bad_comp ? ~num ^ 8'h01 : ~num);
		if (bad_comp)
			return;
		crc = 0;
		for (int i = 0; i < len; i++)
			for (int j = 7; j >= 0; j--) begin
				fb = crc[15] ^ blk[i][j];
				crc = {crc[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
			end
		for (int i = 0; i < (cut > 0 ? cut : len); i++)
			put(KIND_BYTE, blk[i]);
		if (cut > 0)
			return;
		put(KIND_BYTE, crc[15:8]);
		put(KIND_BYTE, crc[7:0] ^ {7'd0, bad_crc});
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = KIND_TICK;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		wr(REG_BASE, 32'hFFFF_FF80);
		wr(REG_MAX, ($urandom_range(0, 3) == 0) ? 32'd100 : 32'hFFFF_FFFF);
		set_timeouts(2, 1, 3, 1);

		// ignored words, then header stage faults
		put(KIND_BAD, 8'hA5);
		put(KIND_BYTE, 8'hFF);
		put(KIND_TICK, 8'h00);
		put(KIND_START, 8'h00);
		ticks(1);
		put(KIND_BYTE, 8'h78);
		put(KIND_BYTE, CAN_B); put(KIND_BYTE, 8'h79);
		put(KIND_BYTE, CAN_B); ticks(1);
		send_block(0, 8'd0, 1, 0, 0, 1, 0);
		send_block(0, 8'd0, 0, 0, 0, 1, $urandom_range(0, 4));
		// data stage faults
		put(KIND_BYTE, 8'h33);
		ticks(3);
		put(KIND_BYTE, CAN_B); put(KIND_BYTE, 8'h00);
		put(KIND_BYTE, CAN_B); ticks(1);
		send_block(0, 8'd1, 1, 0, 0, 0, 0);
		send_block(0, 8'd1, 0, 0, 5, 0, 0); ticks(2);
		send_block(0, 8'd1, 0, 0, 0, 0, 0);
		put(KIND_BYTE, EOT_B);
		// sender holds until every predicted word has drained
		idle_out();

		set_timeouts(1, 1, 1, 1);
		put(KIND_START, 8'h00);
		repeat (16) put(2'($urandom), ($urandom_range(0, 2) == 0) ? CAN_B : 8'($urandom));
		put(KIND_START, 8'h00);
		put(KIND_BYTE, CAN_B);
		put(KIND_BYTE, CAN_B);

		idle_out();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ filelist.f @@
src/ymr_pkg.sv
src/ymr_front.sv
src/ymr_back.sv
src/ymr_regs.sv
src/ymodem_receiver_top.sv
bench/ymr_checker.sv
bench/testbench.sv
